[hdl/doirt_pkg.sv]
package doirt_pkg;

	// CORDIC datapath: Q30 angles and vectors with growth headroom
	localparam int CordicSteps = 30;
	localparam int CordicW     = 35;
	localparam int StepW       = 5;

	// Integer square root: 1 bit of root per step, radicand up to 2^60
	localparam int SqrtW   = 62;
	localparam int SqrtTop = 30;
	localparam int SqrtKW  = 5;
	localparam int RootW   = 31;

	localparam logic signed [CordicW-1:0] CordicGain = 35'sd652032874;

	// Send reason codes
	localparam logic [1:0] REASON_NONE     = 2'd0;
	localparam logic [1:0] REASON_INTERVAL = 2'd1;
	localparam logic [1:0] REASON_DISTANCE = 2'd2;

	typedef struct packed {
		logic start;
		logic vectoring;
	} cordic_ctl_t;

	// Arctangent of 2^-i in Q30
	function automatic logic [CordicW-1:0] atan_q30(input logic [StepW-1:0] i);
		logic [CordicW-1:0] v;
		unique case (i)
			5'd0:    v = 35'd843314857;
			5'd1:    v = 35'd497837829;
			5'd2:    v = 35'd263043837;
			5'd3:    v = 35'd133525159;
			5'd4:    v = 35'd67021687;
			5'd5:    v = 35'd33543516;
			5'd6:    v = 35'd16775851;
			5'd7:    v = 35'd8388437;
			5'd8:    v = 35'd4194283;
			5'd9:    v = 35'd2097149;
			5'd10:   v = 35'd1048576;
			5'd11:   v = 35'd524288;
			5'd12:   v = 35'd262144;
			5'd13:   v = 35'd131072;
			5'd14:   v = 35'd65536;
			5'd15:   v = 35'd32768;
			5'd16:   v = 35'd16384;
			5'd17:   v = 35'd8192;
			5'd18:   v = 35'd4096;
			5'd19:   v = 35'd2048;
			5'd20:   v = 35'd1024;
			5'd21:   v = 35'd512;
			5'd22:   v = 35'd256;
			5'd23:   v = 35'd128;
			5'd24:   v = 35'd64;
			5'd25:   v = 35'd32;
			5'd26:   v = 35'd16;
			5'd27:   v = 35'd8;
			5'd28:   v = 35'd4;
			5'd29:   v = 35'd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[hdl/doirt_cordic.sv]
module doirt_cordic (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  doirt_pkg::cordic_ctl_t                  ctl,
	input  logic signed [doirt_pkg::CordicW-1:0]    x_in,
	input  logic signed [doirt_pkg::CordicW-1:0]    y_in,
	input  logic signed [doirt_pkg::CordicW-1:0]    z_in,
	output logic                                    done,
	output logic signed [doirt_pkg::CordicW-1:0]    x_out,
	output logic signed [doirt_pkg::CordicW-1:0]    y_out,
	output logic signed [doirt_pkg::CordicW-1:0]    z_out
);
	import doirt_pkg::*;

	localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);

	logic                      busy_q;
	logic                      done_q;
	logic                      vec_q;
	logic [StepW-1:0]          step_q;
	logic signed [CordicW-1:0] x_q, y_q, z_q;
	logic signed [CordicW-1:0] dx, dy, at;
	logic                      sigma;

	// One micro-rotation: shifts floor towards minus infinity
	always_comb begin
		dx    = y_q >>> step_q;
		dy    = x_q >>> step_q;
		at    = signed'(atan_q30(step_q));
		sigma = vec_q ? y_q[CordicW-1] : !z_q[CordicW-1];
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vec_q  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				vec_q  <= ctl.vectoring;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Rotate the vector
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (busy_q) begin
			if (sigma) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

[hdl/doirt_isqrt.sv]
module doirt_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [doirt_pkg::SqrtW-1:0]   v_in,
	output logic                          done,
	output logic [doirt_pkg::RootW-1:0]   root
);
	import doirt_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [SqrtKW-1:0] k_q;
	logic [SqrtW-1:0]  v_q, r_q;
	logic [SqrtW-1:0]  b, trial;

	// Trial subtraction for the current root bit
	always_comb begin
		b     = SqrtW'(1) << {k_q, 1'b0};
		trial = r_q + b;
	end

	// Count root bits down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= SqrtKW'(SqrtTop);
			end else if (busy_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	// Build the root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v_in;
			r_q <= '0;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + b;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = r_q[RootW-1:0];

endmodule

[hdl/distance_or_interval_report_trigger.sv]
// Report trigger: each record word (op 0) yields one result word saying whether
// the record is transmitted, on the elapsed time since the last mark or, once a
// record has been accepted, on the haversine distance from the last accepted
// position; a restart word (op 1) restarts the mark. One word is processed at
// a time: a word that needs no distance goes from the decision straight to its
// result, a word that needs the distance runs four 30-step CORDIC rotations,
// two 31-step square roots and one 30-step CORDIC vectoring run one after
// another, the CORDIC runs on a single shared unit, with one shared 33x33
// multiplier. A new word is taken while the previous result still waits.
module distance_or_interval_report_trigger (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [31:0]        now_ms,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic               tx_busy,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               send_now,
	output logic [1:0]         send_reason,
	output logic               send_accepted,
	output logic [24:0]        distance_m,
	output logic               distance_valid
);
	import doirt_pkg::*;

	localparam logic [1:0] CFG_MIN_INTERVAL  = 2'd0;
	localparam logic [1:0] CFG_SEND_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD     = 2'd2;

	localparam logic [32:0] FullTurn    = 33'd3600000000;
	localparam logic [32:0] HalfTurn    = 33'd1800000000;
	localparam logic [32:0] QuarterTurn = 33'd900000000;
	localparam logic [31:0] DegToQ30Lo  = 32'd3753943213;
	localparam logic [30:0] Q30One      = 31'd1073741824;
	localparam logic [60:0] Q60One      = 61'h1000000000000000;
	localparam logic [32:0] TwoRadiusM  = 33'd12734000;
	localparam logic [26:0] DistMax     = 27'd20002610;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECIDE, ST_ANG_DIFF, ST_ANG_FOLD, ST_ANG_MUL, ST_ANG_ROT,
		ST_ROT_WAIT, ST_MUL_CC, ST_RND_CC, ST_MUL_T, ST_RND_T, ST_MUL_SL,
		ST_MUL_TS, ST_SUM, ST_SQRT_HI, ST_WAIT_HI, ST_WAIT_LO, ST_VEC_WAIT,
		ST_MUL_D, ST_DIST, ST_DONE
	} state_t;

	state_t state_q;

	logic [31:0] min_q, send_q;
	logic [24:0] thr_q;
	logic [31:0] mark_q;
	logic signed [30:0] sent_lat_q;
	logic signed [31:0] sent_lon_q;
	logic first_q;

	logic out_valid_q, send_now_q, send_acc_q, dvalid_out_q;
	logic [1:0] reason_out_q;
	logic [24:0] dist_out_q;

	logic op_q, busy_q;
	logic [31:0] now_q;
	logic signed [30:0] lat_q;
	logic signed [31:0] lon_q;
	logic [1:0] reason_q;
	logic dvalid_q;
	logic [24:0] dist_q;

	logic [1:0] k_q;
	logic [32:0] ud_q;
	logic [30:0] uf_q;
	logic neg_q;
	logic [30:0] sl_q, so_q;
	logic signed [31:0] c1_q, c2_q, cc_q, t_q;
	logic [60:0] sl2_q, a60_q;
	logic [30:0] xv_q;
	logic [31:0] angle_q;
	logic signed [65:0] p_q;

	logic signed [32:0] mul_a, mul_b;
	logic [31:0] elapsed;
	logic signed [32:0] da, db, diff;
	logic [32:0] ud, umod, ufold_half, ufold_cos;
	logic ucos_neg;
	logic [64:0] ang_full;
	logic [30:0] ang;
	logic [30:0] cx, cy;
	logic signed [63:0] a_sum;
	logic [56:0] d_sum;
	logic [26:0] d_raw;
	logic [24:0] d_sat;
	logic res_load;

	cordic_ctl_t cordic_ctl;
	logic signed [CordicW-1:0] cx_in, cy_in, cz_in, cx_out, cy_out, cz_out;
	logic cordic_done;
	logic sqrt_start, sqrt_done;
	logic [SqrtW-1:0] sqrt_v;
	logic [RootW-1:0] sqrt_root;

	function automatic logic [30:0] clamp_q30(input logic signed [CordicW-1:0] v);
		logic [30:0] r;
		priority if (v < 0)
			r = '0;
		else if (v > signed'({4'b0, Q30One}))
			r = Q30One;
		else
			r = v[30:0];
		return r;
	endfunction

	// Round a Q60 product to Q30, half away from zero
	function automatic logic signed [31:0] rdiv30(input logic signed [65:0] v);
		logic [65:0] m, r;
		m = v[65] ? 66'(-v) : 66'(v);
		r = (m + 66'd536870912) >> 30;
		return v[65] ? -signed'(r[31:0]) : signed'(r[31:0]);
	endfunction

	// Elapsed time, angle preparation, clamping, sums and result load
	always_comb begin
		elapsed = now_q - mark_q;
		unique case (k_q)
			2'd0: begin
				da = 33'(sent_lat_q);
				db = 33'(lat_q);
			end
			2'd1: begin
				da = 33'(sent_lon_q);
				db = 33'(lon_q);
			end
			2'd2: begin
				da = 33'(sent_lat_q);
				db = '0;
			end
			2'd3: begin
				da = 33'(lat_q);
				db = '0;
			end
		endcase
		diff       = da - db;
		ud         = diff[32] ? 33'(-diff) : 33'(diff);
		umod       = (ud_q >= FullTurn) ? ud_q - FullTurn : ud_q;
		ufold_half = (umod > HalfTurn) ? FullTurn - umod : umod;
		ucos_neg   = ud_q > QuarterTurn;
		ufold_cos  = ucos_neg ? HalfTurn - ud_q : ud_q;
		ang_full   = {1'b0, p_q[63:0]} + ({34'b0, uf_q} << 32)
			+ (k_q[1] ? 65'd2147483648 : 65'd4294967296);
		ang        = k_q[1] ? ang_full[62:32] : ang_full[63:33];
		cx         = clamp_q30(cx_out);
		cy         = clamp_q30(cy_out);
		a_sum      = signed'({3'b0, sl2_q}) + p_q[63:0];
		d_sum      = {1'b0, p_q[55:0]} + 57'd536870912;
		d_raw      = d_sum[56:30];
		d_sat      = (d_raw > DistMax) ? DistMax[24:0] : d_raw[24:0];
		res_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// Select the shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_ANG_MUL: begin
				mul_a = signed'({2'b0, uf_q});
				mul_b = signed'({1'b0, DegToQ30Lo});
			end
			ST_MUL_CC: begin
				mul_a = 33'(c1_q);
				mul_b = 33'(c2_q);
			end
			ST_MUL_T: begin
				mul_a = 33'(cc_q);
				mul_b = signed'({2'b0, so_q});
			end
			ST_MUL_SL: begin
				mul_a = signed'({2'b0, sl_q});
				mul_b = signed'({2'b0, sl_q});
			end
			ST_MUL_TS: begin
				mul_a = 33'(t_q);
				mul_b = signed'({2'b0, so_q});
			end
			ST_MUL_D: begin
				mul_a = signed'({1'b0, angle_q});
				mul_b = signed'(TwoRadiusM);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	// Drive the shared CORDIC and square root units
	always_comb begin
		cordic_ctl.start     = (state_q == ST_ANG_ROT) || (state_q == ST_WAIT_LO && sqrt_done);
		cordic_ctl.vectoring = (state_q == ST_WAIT_LO);
		if (state_q == ST_WAIT_LO) begin
			cx_in = signed'({4'b0, xv_q});
			cy_in = signed'({4'b0, sqrt_root});
			cz_in = '0;
		end else begin
			cx_in = CordicGain;
			cy_in = '0;
			cz_in = signed'({4'b0, ang});
		end
		sqrt_start = (state_q == ST_SQRT_HI) || (state_q == ST_WAIT_HI && sqrt_done);
		sqrt_v     = (state_q == ST_SQRT_HI) ? {1'b0, Q60One - a60_q} : {1'b0, a60_q};
	end

	doirt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cordic_ctl),
		.x_in   (cx_in),
		.y_in   (cy_in),
		.z_in   (cz_in),
		.done   (cordic_done),
		.x_out  (cx_out),
		.y_out  (cy_out),
		.z_out  (cz_out)
	);

	doirt_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.v_in   (sqrt_v),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= 32'd10000;
			send_q <= 32'd60000;
			thr_q  <= 25'd100;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIN_INTERVAL:  min_q  <= cfg_data;
				CFG_SEND_INTERVAL: send_q <= cfg_data;
				CFG_THRESHOLD:     thr_q  <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	// Sequencer, trigger state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mark_q       <= '0;
			sent_lat_q   <= '0;
			sent_lon_q   <= '0;
			first_q      <= 1'b0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			send_now_q   <= 1'b0;
			reason_out_q <= REASON_NONE;
			send_acc_q   <= 1'b0;
			dist_out_q   <= '0;
			dvalid_out_q <= 1'b0;
		end else begin
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					k_q <= '0;
					if (!op_q && elapsed >= min_q && elapsed < send_q && first_q)
						state_q <= ST_ANG_DIFF;
					else
						state_q <= ST_DONE;
				end
				ST_ANG_DIFF: state_q <= ST_ANG_FOLD;
				ST_ANG_FOLD: state_q <= ST_ANG_MUL;
				ST_ANG_MUL:  state_q <= ST_ANG_ROT;
				ST_ANG_ROT:  state_q <= ST_ROT_WAIT;
				ST_ROT_WAIT: begin
					if (cordic_done) begin
						k_q <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? ST_MUL_CC : ST_ANG_DIFF;
					end
				end
				ST_MUL_CC:  state_q <= ST_RND_CC;
				ST_RND_CC:  state_q <= ST_MUL_T;
				ST_MUL_T:   state_q <= ST_RND_T;
				ST_RND_T:   state_q <= ST_MUL_SL;
				ST_MUL_SL:  state_q <= ST_MUL_TS;
				ST_MUL_TS:  state_q <= ST_SUM;
				ST_SUM:     state_q <= ST_SQRT_HI;
				ST_SQRT_HI: state_q <= ST_WAIT_HI;
				ST_WAIT_HI: begin
					if (sqrt_done)
						state_q <= ST_WAIT_LO;
				end
				ST_WAIT_LO: begin
					if (sqrt_done)
						state_q <= ST_VEC_WAIT;
				end
				ST_VEC_WAIT: begin
					if (cordic_done)
						state_q <= ST_MUL_D;
				end
				ST_MUL_D: state_q <= ST_DIST;
				ST_DIST:  state_q <= ST_DONE;
				ST_DONE: begin
					// Hold until the result register is free
					if (res_load) begin
						send_now_q   <= (reason_q != REASON_NONE);
						reason_out_q <= reason_q;
						send_acc_q   <= (reason_q != REASON_NONE) && !busy_q;
						dist_out_q   <= dist_q;
						dvalid_out_q <= dvalid_q;
						if (op_q || reason_q != REASON_NONE)
							mark_q <= now_q;
						if (reason_q != REASON_NONE && !busy_q) begin
							sent_lat_q <= lat_q;
							sent_lon_q <= lon_q;
							first_q    <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item and distance datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q   <= op;
				now_q  <= now_ms;
				lat_q  <= latitude;
				lon_q  <= longitude;
				busy_q <= tx_busy;
			end
			ST_DECIDE: begin
				dist_q   <= '0;
				dvalid_q <= 1'b0;
				if (!op_q && elapsed >= min_q && elapsed >= send_q)
					reason_q <= REASON_INTERVAL;
				else
					reason_q <= REASON_NONE;
			end
			ST_ANG_DIFF: ud_q <= ud;
			ST_ANG_FOLD: begin
				uf_q  <= k_q[1] ? ufold_cos[30:0] : ufold_half[30:0];
				neg_q <= k_q[1] && ucos_neg;
			end
			ST_ROT_WAIT: begin
				if (cordic_done) begin
					unique case (k_q)
						2'd0: sl_q <= cy;
						2'd1: so_q <= cy;
						2'd2: c1_q <= neg_q ? -signed'({1'b0, cx}) : signed'({1'b0, cx});
						2'd3: c2_q <= neg_q ? -signed'({1'b0, cx}) : signed'({1'b0, cx});
					endcase
				end
			end
			ST_RND_CC: cc_q  <= rdiv30(p_q);
			ST_RND_T:  t_q   <= rdiv30(p_q);
			ST_MUL_TS: sl2_q <= p_q[60:0];
			ST_SUM: begin
				// Clamp to [0, 1] in Q60
				priority if (a_sum < 0)
					a60_q <= '0;
				else if (a_sum > signed'({3'b0, Q60One}))
					a60_q <= Q60One;
				else
					a60_q <= a_sum[60:0];
			end
			ST_WAIT_HI: begin
				if (sqrt_done)
					xv_q <= sqrt_root;
			end
			ST_VEC_WAIT: begin
				if (cordic_done)
					angle_q <= cz_out[CordicW-1] ? '0 : cz_out[31:0];
			end
			ST_DIST: begin
				dist_q   <= d_sat;
				dvalid_q <= 1'b1;
				reason_q <= (d_sat >= thr_q) ? REASON_DISTANCE : REASON_NONE;
			end
			default: ;
		endcase
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign send_now       = send_now_q;
	assign send_reason    = reason_out_q;
	assign send_accepted  = send_acc_q;
	assign distance_m     = dist_out_q;
	assign distance_valid = dvalid_out_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside the done state");

	a_dist_not_interval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && distance_valid |-> send_reason != REASON_INTERVAL)
		else $error("distance reported with an interval send");

	a_accept_needs_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_accepted |-> send_now)
		else $error("send accepted without an attempt");

	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == ST_ROT_WAIT || state_q == ST_VEC_WAIT))
		else $error("CORDIC finished while not awaited");

endmodule
